@@ design/hdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_pkg
// shared types, character codes and helpers for the hex dump formatter
// ----------------------------------------------------------------------------
package hdf_pkg;

    localparam int unsigned LINE_BYTES = 16;
    localparam int unsigned SLOT_W     = $clog2(LINE_BYTES);
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned CHAR_W     = 7;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERIOD  = 8'h2e;
    localparam logic [7:0] CH_PIPE    = 8'h7c;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic              we;
        slot_t             waddr;
        logic [CHAR_W-1:0] wdata;
        slot_t             raddr;
    } mem_req_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'd0, nib};
        end
        else
        begin
            ch = 8'h57 + {4'd0, nib};
        end
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] display_char(input logic [7:0] b);
        logic [CHAR_W-1:0] ch;
        if (b < 8'h7f && b > 8'h1f)
        begin
            ch = b[CHAR_W-1:0];
        end
        else
        begin
            ch = CH_PERIOD[CHAR_W-1:0];
        end
        return ch;
    endfunction

endpackage

@@ design/hdf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_if
// valid/ready channels for input bytes and output characters
// ----------------------------------------------------------------------------
interface hdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ design/hdf_line_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_line_mem
// display characters of the current line, one write and one registered read
// ----------------------------------------------------------------------------
module hdf_line_mem (
    input  logic                        clk,
    input  hdf_pkg::mem_req_t           req,
    output logic [hdf_pkg::CHAR_W-1:0]  rd_data
);
    import hdf_pkg::*;

    logic [CHAR_W-1:0] mem [LINE_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

@@ design/hdf_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_seq
// character sequencer: walks the address, hex, pad and text phases of a line
// ----------------------------------------------------------------------------
module hdf_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [hdf_pkg::ADDR_W-1:0]  start_address,
    hdf_in_if.sink                      byte_ch,
    hdf_out_if.source                   char_ch,
    output hdf_pkg::mem_req_t           mem_req,
    input  logic [hdf_pkg::CHAR_W-1:0]  mem_rd_data
);
    import hdf_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_ADDR  = 4'd1;
    localparam logic [3:0] PH_ASP   = 4'd2;
    localparam logic [3:0] PH_HEX   = 4'd3;
    localparam logic [3:0] PH_PAD   = 4'd4;
    localparam logic [3:0] PH_PIPE1 = 4'd5;
    localparam logic [3:0] PH_ASC   = 4'd6;
    localparam logic [3:0] PH_PIPE2 = 4'd7;
    localparam logic [3:0] PH_NL    = 4'd8;

    localparam slot_t SLOT_MID  = slot_t'(LINE_BYTES / 2 - 1);
    localparam slot_t SLOT_LAST = slot_t'(LINE_BYTES - 1);

    logic [3:0]        phase_reg,    phase_next;
    logic [2:0]        cnt_reg,      cnt_next;
    slot_t             slot_reg,     slot_next;
    logic              close_reg,    close_next;
    logic [7:0]        byte_reg,     byte_next;
    logic [ADDR_W-1:0] addr_sh_reg,  addr_sh_next;
    slot_t             pad_slot_reg, pad_slot_next;
    slot_t             asc_idx_reg,  asc_idx_next;
    slot_t             fill_reg,     fill_next;
    logic [ADDR_W-1:0] line_addr_reg, line_addr_next;
    logic              fresh_reg,    fresh_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              load;
    logic [ADDR_W-1:0] eff_addr;
    logic              closing;
    logic              gap_slot;
    logic              gap_pad;
    logic [7:0]        ch;
    logic              ch_last;

    assign accept   = byte_ch.valid && byte_ch.ready;
    assign load     = (phase_reg != PH_IDLE) && (!out_valid_reg || char_ch.ready);
    assign eff_addr = fresh_reg ? start_address : line_addr_reg;
    assign closing  = (fill_reg == SLOT_LAST) || byte_ch.last_byte;
    assign gap_slot = (slot_reg == SLOT_MID) || (slot_reg == SLOT_LAST);
    assign gap_pad  = (pad_slot_reg == SLOT_MID) || (pad_slot_reg == SLOT_LAST);

    assign byte_ch.ready       = (phase_reg == PH_IDLE);
    assign char_ch.valid       = out_valid_reg;
    assign char_ch.out_char    = out_char_reg;
    assign char_ch.last_of_run = out_last_reg;

    always_comb
    begin
        mem_req.we    = accept;
        mem_req.waddr = fill_reg;
        mem_req.wdata = display_char(byte_ch.data_byte);
        if (phase_reg == PH_ASC && load && asc_idx_reg != slot_reg)
        begin
            mem_req.raddr = asc_idx_reg + slot_t'(1);
        end
        else if (phase_reg == PH_ASC)
        begin
            mem_req.raddr = asc_idx_reg;
        end
        else
        begin
            mem_req.raddr = '0;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        close_next     = close_reg;
        byte_next      = byte_reg;
        addr_sh_next   = addr_sh_reg;
        pad_slot_next  = pad_slot_reg;
        asc_idx_next   = asc_idx_reg;
        fill_next      = fill_reg;
        line_addr_next = line_addr_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && !char_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ch             = CH_SPACE;
        ch_last        = 1'b0;

        if (accept)
        begin
            slot_next    = fill_reg;
            close_next   = closing;
            byte_next    = byte_ch.data_byte;
            addr_sh_next = eff_addr;
            cnt_next     = '0;
            fresh_next   = byte_ch.last_byte;
            if (closing)
            begin
                fill_next      = '0;
                line_addr_next = eff_addr + ADDR_W'(LINE_BYTES);
            end
            else
            begin
                fill_next      = fill_reg + slot_t'(1);
                line_addr_next = eff_addr;
            end
            phase_next = (fill_reg == '0) ? PH_ADDR : PH_HEX;
        end

        if (load)
        begin
            unique case (phase_reg)
                PH_ADDR:
                begin
                    ch           = hex_char(addr_sh_reg[ADDR_W-1 -: 4]);
                    addr_sh_next = addr_sh_reg << 4;
                    cnt_next     = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        phase_next = PH_ASP;
                        cnt_next   = '0;
                    end
                end
                PH_ASP:
                begin
                    ch       = CH_SPACE;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd1)
                    begin
                        phase_next = PH_HEX;
                        cnt_next   = '0;
                    end
                end
                PH_HEX:
                begin
                    case (cnt_reg)
                        3'd0:    ch = hex_char(byte_reg[7:4]);
                        3'd1:    ch = hex_char(byte_reg[3:0]);
                        default: ch = CH_SPACE;
                    endcase
                    cnt_next = cnt_reg + 3'd1;
                    if ((cnt_reg == 3'd2 && !gap_slot) || cnt_reg == 3'd3)
                    begin
                        cnt_next = '0;
                        if (!close_reg)
                        begin
                            phase_next = PH_IDLE;
                            ch_last    = 1'b1;
                        end
                        else if (slot_reg == SLOT_LAST)
                        begin
                            phase_next = PH_PIPE1;
                        end
                        else
                        begin
                            phase_next    = PH_PAD;
                            pad_slot_next = slot_reg + slot_t'(1);
                        end
                    end
                end
                PH_PAD:
                begin
                    ch       = CH_SPACE;
                    cnt_next = cnt_reg + 3'd1;
                    if ((cnt_reg == 3'd2 && !gap_pad) || cnt_reg == 3'd3)
                    begin
                        cnt_next = '0;
                        if (pad_slot_reg == SLOT_LAST)
                        begin
                            phase_next = PH_PIPE1;
                        end
                        else
                        begin
                            pad_slot_next = pad_slot_reg + slot_t'(1);
                        end
                    end
                end
                PH_PIPE1:
                begin
                    ch           = CH_PIPE;
                    phase_next   = PH_ASC;
                    asc_idx_next = '0;
                end
                PH_ASC:
                begin
                    ch = {1'b0, mem_rd_data};
                    if (asc_idx_reg == slot_reg)
                    begin
                        phase_next = PH_PIPE2;
                    end
                    else
                    begin
                        asc_idx_next = asc_idx_reg + slot_t'(1);
                    end
                end
                PH_PIPE2:
                begin
                    ch         = CH_PIPE;
                    phase_next = PH_NL;
                end
                PH_NL:
                begin
                    ch         = CH_NEWLINE;
                    ch_last    = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            out_valid_next = 1'b1;
            out_char_next  = ch;
            out_last_next  = ch_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            asc_idx_reg   <= '0;
            pad_slot_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            asc_idx_reg   <= asc_idx_next;
            pad_slot_reg  <= pad_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        close_reg     <= close_next;
        byte_reg      <= byte_next;
        addr_sh_reg   <= addr_sh_next;
        line_addr_reg <= line_addr_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

endmodule

@@ design/hex_dump_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_dump_formatter
// byte stream in, canonical hex dump text out, one character per word
//
// byte_ch carries data_byte and last_byte; a word is taken when valid and
// ready are both high. char_ch carries out_char and last_of_run, which marks
// the final character caused by one input byte. cfg_wr_en/cfg_wr_data load
// start_address, which is used when the next dump begins.
// one byte is worked at a time: it yields 3 to 64 characters, one per cycle
// from the output register while the receiver takes them; the next byte is
// taken once the sequencer is idle again. the sequencer walks the characters;
// the line text is read back from a 16-entry memory one entry per cycle.
// byte_ch.ready is high whenever the sequencer is idle, even while the last
// character still waits in the output register.
// a stalled receiver freezes the sequencer with the character held.
// reset empties the output, starts a fresh dump and clears start_address.
// ----------------------------------------------------------------------------
module hex_dump_formatter (
    input  logic                        clk,
    input  logic                        rst_n,
    hdf_in_if.sink                      byte_ch,
    hdf_out_if.source                   char_ch,
    input  logic                        cfg_wr_en,
    input  logic [hdf_pkg::ADDR_W-1:0]  cfg_wr_data
);
    import hdf_pkg::*;

    logic [ADDR_W-1:0] start_addr_reg;
    mem_req_t          mem_req;
    logic [CHAR_W-1:0] mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            start_addr_reg <= cfg_wr_data;
        end
    end

    hdf_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_address (start_addr_reg),
        .byte_ch       (byte_ch),
        .char_ch       (char_ch),
        .mem_req       (mem_req),
        .mem_rd_data   (mem_rd_data)
    );

    hdf_line_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule
